### hw/rtl/assert_macros.svh
// assertion macros used by vtyp_out_buf
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif

`endif

### hw/rtl/vtyp_pkg.sv
// shared constants, types and the arctangent table of the yaw and pitch converter
package vtyp_pkg;

   localparam int CORDIC_ITERS     = 28;
   localparam int PRE_SHIFT        = 28;
   localparam int ANG_FRAC         = 24;
   localparam int ANGLE_FRAC_BITS  = 7;
   localparam int ANGLE_W          = 35;
   localparam int ATAN_W           = 30;
   localparam int YAW_W            = 16;
   localparam int PITCH_W          = 15;
   localparam int RSP_DATA_W       = ((YAW_W + PITCH_W + 7) / 8) * 8;
   localparam int HALF_TURN_DEG    = 180;
   localparam int QUARTER_TURN_DEG = 90;
   localparam int ROUND_SHIFT      = ANG_FRAC - ANGLE_FRAC_BITS;

   // cordic gain, q30
   localparam logic [30:0] K_Q30 = 31'd1768195363;

   // angles in degrees q24
   localparam logic signed [ANGLE_W-1:0] HALF_TURN    = ANGLE_W'(HALF_TURN_DEG) <<< ANG_FRAC;
   localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(QUARTER_TURN_DEG) <<< ANG_FRAC;

   // output limits, degrees at output scale
   localparam logic signed [ANGLE_W-1:0] YAW_LIMIT =
      ANGLE_W'(HALF_TURN_DEG) <<< ANGLE_FRAC_BITS;
   localparam logic signed [ANGLE_W-1:0] PITCH_LIMIT =
      ANGLE_W'(QUARTER_TURN_DEG) <<< ANGLE_FRAC_BITS;
   localparam logic signed [ANGLE_W-1:0] ROUND_HALF = ANGLE_W'(1) <<< (ROUND_SHIFT - 1);

   typedef struct packed {
      logic x_neg;
      logic x_zero;
      logic z_neg;
      logic z_zero;
   } yaw_flags_type;

   typedef struct packed {
      logic y_neg;
      logic y_zero;
      logic xz_zero;
   } pitch_flags_type;

   // round(atan(2^-idx) degrees * 2^24)
   function automatic logic [ATAN_W-1:0] atan_entry(input int idx);
      case (idx)
         0:       atan_entry = 30'd754974720;
         1:       atan_entry = 30'd445687602;
         2:       atan_entry = 30'd235489088;
         3:       atan_entry = 30'd119537938;
         4:       atan_entry = 30'd60000934;
         5:       atan_entry = 30'd30029717;
         6:       atan_entry = 30'd15018523;
         7:       atan_entry = 30'd7509720;
         8:       atan_entry = 30'd3754917;
         9:       atan_entry = 30'd1877466;
         10:      atan_entry = 30'd938734;
         11:      atan_entry = 30'd469367;
         12:      atan_entry = 30'd234684;
         13:      atan_entry = 30'd117342;
         14:      atan_entry = 30'd58671;
         15:      atan_entry = 30'd29335;
         16:      atan_entry = 30'd14668;
         17:      atan_entry = 30'd7334;
         18:      atan_entry = 30'd3667;
         19:      atan_entry = 30'd1833;
         20:      atan_entry = 30'd917;
         21:      atan_entry = 30'd458;
         22:      atan_entry = 30'd229;
         23:      atan_entry = 30'd115;
         24:      atan_entry = 30'd57;
         25:      atan_entry = 30'd29;
         26:      atan_entry = 30'd14;
         27:      atan_entry = 30'd7;
         default: atan_entry = '0;
      endcase
   endfunction

endpackage

### hw/rtl/vector_to_yaw_pitch_top.sv
// vector to yaw and pitch converter, top level
// item path: input, yaw cordic chain, middle, pitch cordic chain, final, output register
// one item per cycle unless the skid is full; two fully pipelined 28-stage cordic chains
// an output register plus a one-item skid buffer keep req_tready high while a result waits
// reset clears every stage valid bit and the output buffer; data registers are not reset
module vector_to_yaw_pitch_top
   import vtyp_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [((3*COORD_BITS+7)/8)*8-1:0]    req_tdata,  // x_coord, y_coord, z_coord
   // result channel
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [RSP_DATA_W-1:0]                rsp_tdata   // yaw_angle, pitch_angle
);

   // cordic datapath width: coordinate, pre-scale, sign and gain headroom
   localparam int CW           = COORD_BITS + PRE_SHIFT + 3;
   localparam int YAW_SIDE_W   = COORD_BITS + $bits(yaw_flags_type) + $bits(pitch_flags_type);
   localparam int PITCH_SIDE_W = YAW_W + $bits(pitch_flags_type);

   localparam logic signed [CW-1:0] K_WIDE = CW'(K_Q30);

   // round half up, floor shift, clamp to +-limit
   function automatic logic signed [ANGLE_W-1:0] round_angle(
      input logic signed [ANGLE_W-1:0] angle,
      input logic signed [ANGLE_W-1:0] limit
   );
      logic signed [ANGLE_W-1:0] shifted;
      shifted = (angle + ROUND_HALF) >>> ROUND_SHIFT;
      if (shifted > limit) begin
         round_angle = limit;
      end else if (shifted < -limit) begin
         round_angle = -limit;
      end else begin
         round_angle = shifted;
      end
   endfunction

   logic advance;

   // ---------------------------------------------------------------
   // input stage: unpack, fold into the right half plane, edge flags
   // ---------------------------------------------------------------
   logic signed [COORD_BITS-1:0] x_coord, y_coord, z_coord;
   logic signed [CW-1:0]         x_ext, z_ext;
   logic signed [CW-1:0]         x0_in, x0_ff, z0_in, z0_ff;
   yaw_flags_type                yaw_flags_in;
   pitch_flags_type              pitch_flags_in;
   logic [YAW_SIDE_W-1:0]        side0_in, side0_ff;
   logic                         valid0_ff;

   assign x_coord = req_tdata[COORD_BITS-1:0];
   assign y_coord = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign z_coord = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   assign x_ext = CW'(x_coord);
   assign z_ext = CW'(z_coord);

   assign yaw_flags_in.x_neg    = x_coord[COORD_BITS-1];
   assign yaw_flags_in.x_zero   = (x_coord == '0);
   assign yaw_flags_in.z_neg    = z_coord[COORD_BITS-1];
   assign yaw_flags_in.z_zero   = (z_coord == '0);
   assign pitch_flags_in.y_neg  = y_coord[COORD_BITS-1];
   assign pitch_flags_in.y_zero = (y_coord == '0);
   // horizontal length is zero exactly when x and z are both zero
   assign pitch_flags_in.xz_zero = yaw_flags_in.x_zero & yaw_flags_in.z_zero;

   // negative x: turn the vector by half a turn, base angle added back later
   assign x0_in = (yaw_flags_in.x_neg ? -x_ext : x_ext) <<< PRE_SHIFT;
   assign z0_in = (yaw_flags_in.x_neg ? -z_ext : z_ext) <<< PRE_SHIFT;

   assign side0_in = {y_coord, yaw_flags_in, pitch_flags_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (advance) begin
         valid0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x0_ff    <= x0_in;
         z0_ff    <= z0_in;
         side0_ff <= side0_in;
      end
   end

   // ---------------------------------------------------------------
   // yaw cordic: drives z to zero, leaves the horizontal magnitude
   // ---------------------------------------------------------------
   logic                      yaw_valid;
   logic signed [CW-1:0]      yaw_mag;
   logic signed [ANGLE_W-1:0] yaw_acc;
   logic [YAW_SIDE_W-1:0]     yaw_side;

   vtyp_cordic_pipe #(
      .DATA_W (CW),
      .SIDE_W (YAW_SIDE_W)
   ) u_yaw_pipe (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (valid0_ff),
      .in_x      (x0_ff),
      .in_y      (z0_ff),
      .in_side   (side0_ff),
      .out_valid (yaw_valid),
      .out_x     (yaw_mag),
      .out_acc   (yaw_acc),
      .out_side  (yaw_side)
   );

   // ---------------------------------------------------------------
   // middle stage: finish yaw, gain-scale y for the pitch cordic
   // ---------------------------------------------------------------
   logic signed [COORD_BITS-1:0] mid_y_coord;
   yaw_flags_type                mid_yaw_flags;
   pitch_flags_type              mid_pitch_flags, mid_pitch_flags_ff;
   logic signed [ANGLE_W-1:0]    yaw_raw;
   logic [YAW_W-1:0]             yaw_round_in, yaw_round_ff;
   logic signed [CW-1:0]         ys_prod_in, ys_prod_ff;
   logic signed [CW-1:0]         pitch_x_ff, pitch_y0;
   logic                         mid_valid_ff;

   assign {mid_y_coord, mid_yaw_flags, mid_pitch_flags} = yaw_side;

   always_comb begin
      if (mid_yaw_flags.z_zero) begin
         // on the x axis, or the zero vector
         yaw_raw = mid_yaw_flags.x_neg ? HALF_TURN : '0;
      end else if (mid_yaw_flags.x_zero) begin
         // on the z axis
         yaw_raw = mid_yaw_flags.z_neg ? -QUARTER_TURN : QUARTER_TURN;
      end else if (mid_yaw_flags.x_neg) begin
         yaw_raw = yaw_acc + (mid_yaw_flags.z_neg ? -HALF_TURN : HALF_TURN);
      end else begin
         yaw_raw = yaw_acc;
      end
   end

   assign yaw_round_in = YAW_W'(round_angle(yaw_raw, YAW_LIMIT));
   // y times the cordic gain so that it matches the magnitude scale
   assign ys_prod_in   = CW'(mid_y_coord) * K_WIDE;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
      end else if (advance) begin
         mid_valid_ff <= yaw_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pitch_x_ff         <= yaw_mag;
         ys_prod_ff         <= ys_prod_in;
         yaw_round_ff       <= yaw_round_in;
         mid_pitch_flags_ff <= mid_pitch_flags;
      end
   end

   // gain is held in q30, product brought to the q28 scale by a floor shift
   assign pitch_y0 = ys_prod_ff >>> 2;

   // ---------------------------------------------------------------
   // pitch cordic: angle of (magnitude, scaled y)
   // ---------------------------------------------------------------
   logic                      pitch_valid;
   logic signed [ANGLE_W-1:0] pitch_acc;
   logic [PITCH_SIDE_W-1:0]   pitch_side;

   vtyp_cordic_pipe #(
      .DATA_W (CW),
      .SIDE_W (PITCH_SIDE_W)
   ) u_pitch_pipe (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (mid_valid_ff),
      .in_x      (pitch_x_ff),
      .in_y      (pitch_y0),
      .in_side   ({yaw_round_ff, mid_pitch_flags_ff}),
      .out_valid (pitch_valid),
      .out_x     (),
      .out_acc   (pitch_acc),
      .out_side  (pitch_side)
   );

   // ---------------------------------------------------------------
   // final stage: finish pitch, pack the result item
   // ---------------------------------------------------------------
   logic [YAW_W-1:0]          fin_yaw;
   pitch_flags_type           fin_pitch_flags;
   logic signed [ANGLE_W-1:0] pitch_raw;
   logic [PITCH_W-1:0]        pitch_round;
   logic [RSP_DATA_W-1:0]     round_data_in, round_data_ff;
   logic                      round_valid_ff;

   assign {fin_yaw, fin_pitch_flags} = pitch_side;

   always_comb begin
      if (fin_pitch_flags.y_zero) begin
         pitch_raw = '0;
      end else if (fin_pitch_flags.xz_zero) begin
         // straight up or down
         pitch_raw = fin_pitch_flags.y_neg ? -QUARTER_TURN : QUARTER_TURN;
      end else begin
         pitch_raw = pitch_acc;
      end
   end

   assign pitch_round   = PITCH_W'(round_angle(pitch_raw, PITCH_LIMIT));
   assign round_data_in = RSP_DATA_W'({pitch_round, fin_yaw});

   always_ff @(posedge clock) begin
      if (reset) begin
         round_valid_ff <= 1'b0;
      end else if (advance) begin
         round_valid_ff <= pitch_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         round_data_ff <= round_data_in;
      end
   end

   // ---------------------------------------------------------------
   // output register and skid; the whole pipe moves while the skid is empty
   // ---------------------------------------------------------------
   vtyp_out_buf #(
      .DATA_W (RSP_DATA_W)
   ) u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (round_valid_ff),
      .in_data   (round_data_ff),
      .in_ready  (advance),
      .out_valid (rsp_tvalid),
      .out_data  (rsp_tdata),
      .out_ready (rsp_tready)
   );

   assign req_tready = advance;

endmodule

### hw/rtl/vtyp_cordic_stage.sv
// one registered cordic vectoring micro-rotation
module vtyp_cordic_stage
   import vtyp_pkg::*;
#(
   parameter int DATA_W    = 47,
   parameter int SIDE_W    = 8,
   parameter int STAGE_IDX = 0
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic signed [DATA_W-1:0]  in_x,
   input  logic signed [DATA_W-1:0]  in_y,
   input  logic signed [ANGLE_W-1:0] in_acc,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic signed [DATA_W-1:0]  out_x,
   output logic signed [DATA_W-1:0]  out_y,
   output logic signed [ANGLE_W-1:0] out_acc,
   output logic [SIDE_W-1:0]         out_side
);

   localparam logic signed [ANGLE_W-1:0] STEP_ANGLE = ANGLE_W'(atan_entry(STAGE_IDX));

   logic                      valid_ff;
   logic signed [DATA_W-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0] acc_ff, acc_in;
   logic [SIDE_W-1:0]         side_ff;
   logic signed [DATA_W-1:0]  x_shift, y_shift;
   logic                      rotate_down;

   // floor shifts
   assign x_shift     = in_x >>> STAGE_IDX;
   assign y_shift     = in_y >>> STAGE_IDX;
   assign rotate_down = ~in_y[DATA_W-1];

   always_comb begin
      if (rotate_down) begin
         x_in   = in_x + y_shift;
         y_in   = in_y - x_shift;
         acc_in = in_acc + STEP_ANGLE;
      end else begin
         x_in   = in_x - y_shift;
         y_in   = in_y + x_shift;
         acc_in = in_acc - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_acc   = acc_ff;
   assign out_side  = side_ff;

endmodule

### hw/rtl/vtyp_cordic_pipe.sv
// chain of cordic vectoring stages, one micro-rotation per register stage
module vtyp_cordic_pipe
   import vtyp_pkg::*;
#(
   parameter int DATA_W = 47,
   parameter int SIDE_W = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      enable,
   input  logic                      in_valid,
   input  logic signed [DATA_W-1:0]  in_x,
   input  logic signed [DATA_W-1:0]  in_y,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic signed [DATA_W-1:0]  out_x,
   output logic signed [ANGLE_W-1:0] out_acc,
   output logic [SIDE_W-1:0]         out_side
);

   logic                      valid_chain [CORDIC_ITERS+1];
   logic signed [DATA_W-1:0]  x_chain     [CORDIC_ITERS+1];
   logic signed [DATA_W-1:0]  y_chain     [CORDIC_ITERS+1];
   logic signed [ANGLE_W-1:0] acc_chain   [CORDIC_ITERS+1];
   logic [SIDE_W-1:0]         side_chain  [CORDIC_ITERS+1];

   assign valid_chain[0] = in_valid;
   assign x_chain[0]     = in_x;
   assign y_chain[0]     = in_y;
   assign acc_chain[0]   = '0;
   assign side_chain[0]  = in_side;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_stage
      vtyp_cordic_stage #(
         .DATA_W    (DATA_W),
         .SIDE_W    (SIDE_W),
         .STAGE_IDX (i)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .in_valid  (valid_chain[i]),
         .in_x      (x_chain[i]),
         .in_y      (y_chain[i]),
         .in_acc    (acc_chain[i]),
         .in_side   (side_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_x     (x_chain[i+1]),
         .out_y     (y_chain[i+1]),
         .out_acc   (acc_chain[i+1]),
         .out_side  (side_chain[i+1])
      );
   end

   assign out_valid = valid_chain[CORDIC_ITERS];
   assign out_x     = x_chain[CORDIC_ITERS];
   assign out_acc   = acc_chain[CORDIC_ITERS];
   assign out_side  = side_chain[CORDIC_ITERS];

endmodule

### hw/rtl/vtyp_out_buf.sv
// output register with a one-item skid buffer
`include "assert_macros.svh"

module vtyp_out_buf #(
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [DATA_W-1:0] in_data,
   output logic              in_ready,
   output logic              out_valid,
   output logic [DATA_W-1:0] out_data,
   input  logic              out_ready
);

   logic              main_valid_ff, main_valid_in, skid_valid_ff, skid_valid_in;
   logic [DATA_W-1:0] main_data_ff, main_data_in, skid_data_ff, skid_data_in;
   logic              in_fire, main_free;

   assign in_ready  = ~skid_valid_ff;
   assign in_fire   = in_valid & ~skid_valid_ff;
   assign main_free = ~main_valid_ff | out_ready;

   always_comb begin
      main_valid_in = main_valid_ff;
      main_data_in  = main_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_data_in  = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_fire;
            main_data_in  = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_data_ff <= main_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_data_ff;

   `ASSERT_NEVER(skid_without_main, clock, reset, skid_valid_ff && !main_valid_ff, "skid item ahead of output register")
   `ASSERT_PROP(skid_fill_on_stall, clock, reset, $rose(skid_valid_ff) |-> $past(main_valid_ff && !out_ready), "skid filled while output was free")
   `ASSERT_PROP(skid_drains, clock, reset, skid_valid_ff && out_ready |=> main_valid_ff && !skid_valid_ff, "skid item not moved to output register")

endmodule
